### sv/pepper_noise_island_removal_unit_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the pepper noise island removal unit
// Concurrent checks clocked on clk_i and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef PEPPER_NOISE_ISLAND_REMOVAL_UNIT_MACROS_SVH
`define PEPPER_NOISE_ISLAND_REMOVAL_UNIT_MACROS_SVH

`ifndef SYNTH
// property must hold at every clock edge outside reset
`define PNIR_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("pnir assertion failed");
// condition must never be true outside reset
`define PNIR_ASSERT_NEVER(name, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("pnir forbidden condition seen");
`else
`define PNIR_ASSERT(name, prop)
`define PNIR_ASSERT_NEVER(name, cond)
`endif

`endif

### sv/pnir_pkg.sv
// ---------------------------------------------------------------------------
// pnir_pkg
// Shared types, constants and helpers of the pepper noise island remover.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pnir_pkg;

  localparam int unsigned ROWS  = 5;   // rows held in the line ring
  localparam int unsigned CFG_W = 11;  // width of the size registers

  typedef logic [7:0]            pix_t;
  typedef logic [2:0]            slot_t;  // ring slot, 0..ROWS-1
  typedef logic [ROWS-1:0][7:0]  col_t;   // one column, slot indexed

  localparam pix_t WHITE_FILL = 8'd255;
  localparam int unsigned SKIP_COLUMNS  = 2;
  localparam int unsigned CENTRE_OFFSET = 2;

  localparam logic [CFG_W-1:0] RST_WIDTH  = 11'd640;
  localparam logic [CFG_W-1:0] RST_HEIGHT = 11'd480;

  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1
  } cfg_idx_e;

  // per-item control handed from the sequencer to the window
  typedef struct packed {
    logic  step;       // item is processed this cycle
    logic  new_row;    // item is in column zero
    logic  centre_en;  // item makes a centre test
    slot_t base;       // slot of the oldest window row
    slot_t wslot;      // slot of the newest row
  } step_ctl_t;

  typedef struct packed {
    pix_t pixel;
    logic last;
  } out_item_t;

  function automatic slot_t slot_add(slot_t a, slot_t b);
    logic [3:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= 4'(ROWS)) s = s - 4'(ROWS);
    return s[2:0];
  endfunction

  function automatic slot_t slot_inc(slot_t a);
    return slot_add(a, 3'd1);
  endfunction

endpackage

`default_nettype wire

### sv/pnir_if.sv
// ---------------------------------------------------------------------------
// pnir_if
// Valid/ready channels of the island remover: pixels in, pixels out, config.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface pnir_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_in;
  logic       frame_start;
  modport source (output valid, output pixel_in, output frame_start, input ready);
  modport sink   (input valid, input pixel_in, input frame_start, output ready);
endinterface

interface pnir_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_out;
  logic       frame_last;
  modport source (output valid, output pixel_out, output frame_last, input ready);
  modport sink   (input valid, input pixel_out, input frame_last, output ready);
endinterface

interface pnir_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [10:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### sv/pnir_line_mem.sv
// ---------------------------------------------------------------------------
// pnir_line_mem
// Column memory: one word holds the five ring rows of a column.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pnir_line_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  wire                logic          clk_i,
  input  wire                logic          rd_en_i,
  input  wire                logic [AW-1:0] rd_addr_i,
  output pnir_pkg::col_t                    rd_data_o,
  input  wire                logic          wr_en_i,
  input  wire                logic [AW-1:0] wr_addr_i,
  input  pnir_pkg::col_t                    wr_data_i
);
  import pnir_pkg::*;

  col_t mem [DEPTH];

  // one write and one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem[wr_addr_i] <= wr_data_i;
    if (rd_en_i) rd_data_o <= mem[rd_addr_i];
  end

endmodule

`default_nettype wire

### sv/pnir_window.sv
// ---------------------------------------------------------------------------
// pnir_window
// 5x5 window registers, island test, write-back and row-end flush buffer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pnir_window #(
  parameter int unsigned CW = 10
) (
  input  wire                logic          clk_i,
  input  wire                logic          rst_ni,
  input  pnir_pkg::step_ctl_t               ctl_i,
  input  wire                logic [CW-1:0] col_i,
  input  pnir_pkg::pix_t                    pix_i,
  input  pnir_pkg::col_t                    rd_data_i,
  output logic                              wr_en_o,
  output logic               [CW-1:0]       wr_addr_o,
  output pnir_pkg::col_t                    wr_data_o,
  output pnir_pkg::pix_t                    out_pix_o,
  output logic                              black_o
);
  import pnir_pkg::*;

  localparam int unsigned WIN = 5;
  localparam int unsigned FL  = WIN - 1;

  col_t          win_q [WIN];
  col_t          win_d [WIN];
  logic [CW-1:0] wa_q  [WIN];
  logic [CW-1:0] wa_d  [WIN];
  logic [WIN-1:0] wv_q, wv_d;

  col_t          fl_q [FL];
  col_t          fl_d [FL];
  logic [CW-1:0] fa_q [FL];
  logic [CW-1:0] fa_d [FL];
  logic [FL-1:0] fv_q, fv_d;

  // write of the cycle in which the current read was issued
  logic          lw_v_q;
  logic [CW-1:0] lw_a_q;
  col_t          lw_d_q;

  col_t fwd;
  col_t incoming;
  logic found;
  logic black;
  logic ring;

  // newest copy of the column being read
  always_comb begin
    fwd = rd_data_i;
    if (lw_v_q && lw_a_q == col_i) fwd = lw_d_q;
    for (int i = 0; i < FL; i++) begin
      if (fv_q[i] && fa_q[i] == col_i) fwd = fl_q[i];
    end
    for (int k = 0; k < WIN; k++) begin
      if (wv_q[k] && wa_q[k] == col_i) fwd = win_q[k];
    end
    incoming = fwd;
    incoming[ctl_i.wslot] = pix_i;
  end

  assign out_pix_o = fwd[ctl_i.base];

  // shift, write-back, flush and island clearing
  always_comb begin
    win_d     = win_q;
    wa_d      = wa_q;
    wv_d      = wv_q;
    fl_d      = fl_q;
    fa_d      = fa_q;
    fv_d      = fv_q;
    wr_en_o   = 1'b0;
    wr_addr_o = wa_q[0];
    wr_data_o = win_q[0];
    found     = 1'b0;

    if (ctl_i.step) begin
      wr_en_o = wv_q[0];
      for (int k = 0; k < WIN - 1; k++) begin
        win_d[k] = win_q[k+1];
        wa_d[k]  = wa_q[k+1];
        wv_d[k]  = ctl_i.new_row ? 1'b0 : wv_q[k+1];
      end
      win_d[WIN-1] = incoming;
      wa_d[WIN-1]  = col_i;
      wv_d[WIN-1]  = 1'b1;
      // previous row leaves the window at column zero
      if (ctl_i.new_row) begin
        for (int i = 0; i < FL; i++) begin
          fl_d[i] = win_q[i+1];
          fa_d[i] = wa_q[i+1];
          fv_d[i] = wv_q[i+1];
        end
      end
    end

    // drain one flush entry when the port is free
    if (!wr_en_o && !(ctl_i.step && ctl_i.new_row)) begin
      for (int i = 0; i < FL; i++) begin
        if (fv_q[i] && !found) begin
          found     = 1'b1;
          wr_en_o   = 1'b1;
          wr_addr_o = fa_q[i];
          wr_data_o = fl_q[i];
          fv_d[i]   = 1'b0;
        end
      end
    end

    // island test on the shifted window, logical rows via the ring base
    black = (win_d[2][slot_add(ctl_i.base, 3'd2)] == 8'd0);
    ring  = 1'b1;
    for (int k = 0; k < WIN; k++) begin
      if (win_d[k][ctl_i.base] == 8'd0) ring = 1'b0;
      if (win_d[k][slot_add(ctl_i.base, 3'd4)] == 8'd0) ring = 1'b0;
    end
    for (int i = 1; i < WIN - 1; i++) begin
      if (win_d[0][slot_add(ctl_i.base, 3'(i))] == 8'd0) ring = 1'b0;
      if (win_d[WIN-1][slot_add(ctl_i.base, 3'(i))] == 8'd0) ring = 1'b0;
    end
    if (ctl_i.centre_en && black && ring) begin
      for (int i = 1; i < WIN - 1; i++) begin
        for (int k = 1; k < WIN - 1; k++) begin
          win_d[k][slot_add(ctl_i.base, 3'(i))] = WHITE_FILL;
        end
      end
    end
  end

  assign black_o = black;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wv_q   <= '0;
      fv_q   <= '0;
      lw_v_q <= 1'b0;
    end else begin
      wv_q   <= wv_d;
      fv_q   <= fv_d;
      lw_v_q <= wr_en_o;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    win_q  <= win_d;
    wa_q   <= wa_d;
    fl_q   <= fl_d;
    fa_q   <= fa_d;
    lw_a_q <= wr_addr_o;
    lw_d_q <= wr_data_o;
  end

endmodule

`default_nettype wire

### sv/pnir_out_fifo.sv
// ---------------------------------------------------------------------------
// pnir_out_fifo
// Two-entry output buffer that parts the pipeline from the output channel.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pnir_out_fifo (
  input  wire                logic       clk_i,
  input  wire                logic       rst_ni,
  input  wire                logic       push_i,
  input  pnir_pkg::out_item_t            data_i,
  input  wire                logic       pop_i,
  output logic                           valid_o,
  output pnir_pkg::out_item_t            data_o,
  output logic               [1:0]       cnt_o
);
  import pnir_pkg::*;

  out_item_t mem_q [2];
  logic      wp_q, rp_q;
  logic [1:0] cnt_q;

  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rp_q];
  assign cnt_o   = cnt_q;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

endmodule

`default_nettype wire

### sv/pepper_noise_island_removal_unit.sv
// A pixel leaves after the pixel four rows below it is accepted, via the window
// stage registers and the output buffer. Throughput: one pixel per clock while the
// output takes pixels, set by the single read and write port of the column memory
// (one word per column, all five ring rows) and the window stage. Reset: counters,
// valid bits and the output buffer clear at once; the column memory is not cleared.
// ---------------------------------------------------------------------------
// pepper_noise_island_removal_unit
// Streams a binary mask and fills white the inner 3x3 around a black
// centre pixel inside a white 5x5 ring; output runs four rows behind the input.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "pepper_noise_island_removal_unit_macros.svh"

module pepper_noise_island_removal_unit #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  pnir_in_if.sink      pix_i,
  pnir_out_if.source   pix_o,
  pnir_cfg_if.sink     cfg_i
);
  import pnir_pkg::*;

  localparam int unsigned CW  = $clog2(MAX_WIDTH);
  localparam int unsigned RW  = $clog2(MAX_HEIGHT + 5);
  localparam int unsigned CW1 = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW1 = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned M1  = (CW1 > CFG_W) ? CW1 : CFG_W;
  localparam int unsigned M2  = (HW1 > RW) ? HW1 : RW;
  localparam int unsigned EW  = ((M1 > M2) ? M1 : M2) + 1;

  // configuration
  logic [CFG_W-1:0] width_q, height_q;
  logic [EW-1:0]    w_eff, h_eff;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RST_WIDTH;
      height_q <= RST_HEIGHT;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_WIDTH:  width_q  <= cfg_i.data;
        CFG_HEIGHT: height_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q == '0)                        w_eff = EW'(1);
    else if (EW'(width_q) > EW'(MAX_WIDTH))   w_eff = EW'(MAX_WIDTH);
    else                                      w_eff = EW'(width_q);
    if (height_q == '0)                       h_eff = EW'(1);
    else if (EW'(height_q) > EW'(MAX_HEIGHT)) h_eff = EW'(MAX_HEIGHT);
    else                                      h_eff = EW'(height_q);
  end

  // input side: position of the accepted item
  logic [CW-1:0] col_q, col_s, col_n;
  logic [RW-1:0] row_q, row_s, row_n;
  slot_t         rmod_q, rmod_s, rmod_n;
  logic [EW-1:0] colp;
  logic          ign_s;
  logic          in_acc;
  logic          pop;
  logic [1:0]    fifo_cnt;
  logic          s1_v_q;

  assign pop         = pix_o.valid & pix_o.ready;
  assign pix_i.ready = ({1'b0, fifo_cnt} + {2'b00, s1_v_q}) <= (3'd1 + {2'b00, pop});
  assign in_acc      = pix_i.valid & pix_i.ready;

  always_comb begin
    col_s  = col_q;
    row_s  = row_q;
    rmod_s = rmod_q;
    if (pix_i.frame_start) begin
      col_s  = '0;
      row_s  = '0;
      rmod_s = '0;
    end
    if (EW'(col_s) >= w_eff) begin
      col_s  = '0;
      row_s  = row_s + 1'b1;
      rmod_s = slot_inc(rmod_s);
    end
    ign_s = (EW'(row_s) >= h_eff + EW'(4));
    colp  = EW'(col_s) + EW'(1);
    if (ign_s) begin
      col_n  = col_s;
      row_n  = row_s;
      rmod_n = rmod_s;
    end else if (colp >= w_eff) begin
      col_n  = '0;
      row_n  = row_s + 1'b1;
      rmod_n = slot_inc(rmod_s);
    end else begin
      col_n  = colp[CW-1:0];
      row_n  = row_s;
      rmod_n = rmod_s;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      rmod_q <= '0;
    end else if (in_acc) begin
      col_q  <= col_n;
      row_q  <= row_n;
      rmod_q <= rmod_n;
    end
  end

  // window stage registers
  logic          s1_ign_q;
  logic [CW-1:0] s1_col_q;
  logic [RW-1:0] s1_row_q;
  slot_t         s1_rmod_q;
  pix_t          s1_pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_v_q <= 1'b0;
    else         s1_v_q <= in_acc;
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_ign_q  <= ign_s;
      s1_col_q  <= col_s;
      s1_row_q  <= row_s;
      s1_rmod_q <= rmod_s;
      s1_pix_q  <= pix_i.pixel_in;
    end
  end

  // centre selection
  logic [EW-1:0] ncc_q, ncc_eff;
  step_ctl_t     ctl;
  logic          black;
  logic          push;
  out_item_t     item;
  pix_t          out_pix;

  always_comb begin
    ncc_eff       = (s1_col_q == '0) ? EW'(CENTRE_OFFSET) : ncc_q;
    ctl.step      = s1_v_q & ~s1_ign_q;
    ctl.new_row   = (s1_col_q == '0);
    ctl.wslot     = s1_rmod_q;
    ctl.base      = slot_inc(s1_rmod_q);
    ctl.centre_en = ctl.step
                  && (EW'(s1_row_q) >= EW'(4))
                  && (EW'(s1_row_q) + EW'(1) <= h_eff)
                  && (EW'(s1_col_q) >= EW'(4))
                  && (EW'(s1_col_q) == ncc_eff + EW'(CENTRE_OFFSET));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ncc_q <= EW'(CENTRE_OFFSET);
    end else if (ctl.centre_en) begin
      ncc_q <= black ? EW'(s1_col_q) + EW'(SKIP_COLUMNS) - EW'(1)
                     : EW'(s1_col_q) - EW'(1);
    end else if (ctl.step) begin
      ncc_q <= ncc_eff;
    end
  end

  // column memory and window
  col_t          rd_data;
  logic          wr_en;
  logic [CW-1:0] wr_addr;
  col_t          wr_data;

  pnir_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_mem (
    .clk_i     (clk_i),
    .rd_en_i   (in_acc),
    .rd_addr_i (col_s),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  pnir_window #(
    .CW (CW)
  ) u_win (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .col_i     (s1_col_q),
    .pix_i     (s1_pix_q),
    .rd_data_i (rd_data),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_data),
    .out_pix_o (out_pix),
    .black_o   (black)
  );

  // output buffer
  assign push       = ctl.step && (EW'(s1_row_q) >= EW'(4));
  assign item.pixel = out_pix;
  assign item.last  = ctl.step && (EW'(s1_row_q) == h_eff + EW'(3))
                    && (EW'(s1_col_q) + EW'(1) == w_eff);

  out_item_t head;

  pnir_out_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (item),
    .pop_i   (pop),
    .valid_o (pix_o.valid),
    .data_o  (head),
    .cnt_o   (fifo_cnt)
  );

  assign pix_o.pixel_out  = head.pixel;
  assign pix_o.frame_last = head.last;

  // checks
  `PNIR_ASSERT(a_warmup_no_result, (in_acc && (EW'(row_s) < EW'(4))) |=> !push)
  `PNIR_ASSERT(a_stall_needs_backlog, !pix_i.ready |-> (fifo_cnt != 2'd0))
  `PNIR_ASSERT_NEVER(a_fifo_overflow, (fifo_cnt == 2'd2) && push && !pop)

endmodule

`default_nettype wire
